### src/block_move_engine_top_macros.svh
// ----------------------------------------------------------------------------
// Block move engine assertion macros
// Concurrent check wrappers, removed when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef BLOCK_MOVE_ENGINE_TOP_MACROS_SVH
`define BLOCK_MOVE_ENGINE_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define BME_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("block move engine check failed");
`define BME_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("block move engine check failed");
`else
`define BME_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define BME_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

### src/bme_pkg.sv
// ----------------------------------------------------------------------------
// Block move engine package
// Transaction types, codes and tick constants shared by the engine modules.
// ----------------------------------------------------------------------------
package bme_pkg;

  localparam int AddrW = 16;

  localparam logic OP_START = 1'b0;
  localparam logic OP_DATA  = 1'b1;

  localparam logic [1:0] SPACE_MEM = 2'd0;
  localparam logic [1:0] SPACE_IIO = 2'd1;
  localparam logic [1:0] SPACE_XIO = 2'd2;
  localparam logic [1:0] SPACE_BAD = 2'd3;

  localparam logic [1:0] ADV_BOTH = 2'd0;
  localparam logic [1:0] ADV_SRC  = 2'd1;
  localparam logic [1:0] ADV_DST  = 2'd2;
  localparam logic [1:0] ADV_BAD  = 2'd3;

  localparam logic [3:0] CYC_NONE        = 4'd0;
  localparam logic [3:0] CYC_REP_START   = 4'd5;
  localparam logic [3:0] CYC_REP_BYTE    = 4'd7;
  localparam logic [3:0] CYC_SINGLE_BYTE = 4'd9;

  typedef struct packed {
    logic        operation;
    logic [15:0] src_addr;
    logic [15:0] dst_addr;
    logic [15:0] byte_count;
    logic        direction;
    logic [1:0]  advance_mode;
    logic        io_side;
    logic [1:0]  space;
    logic        repeat_req;
    logic [7:0]  read_data;
  } item_t;

  typedef struct packed {
    logic        write_valid;
    logic [15:0] write_addr;
    logic [7:0]  write_data;
    logic [1:0]  write_space;
    logic [15:0] read_addr;
    logic [1:0]  read_space;
    logic        done_res;
    logic [15:0] count_left;
    logic [15:0] src_now;
    logic [15:0] dst_now;
    logic        flag_v;
    logic [3:0]  cycles;
  } result_t;

  typedef struct packed {
    logic       direction;
    logic [1:0] advance;
    logic       io_side;
    logic [1:0] space;
    logic       repeat_req;
  } mode_t;

  typedef struct packed {
    logic             is_start;
    logic [AddrW-1:0] src;
    logic [AddrW-1:0] dst;
    logic [15:0]      count;
    mode_t            mode;
    logic [7:0]       data;
  } cmd_t;

endpackage

### src/bme_front.sv
// ----------------------------------------------------------------------------
// Block move engine front end
// Accepts transactions, decodes start and data items and queues them for the back end.
// ----------------------------------------------------------------------------
module bme_front import bme_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  output logic  full_o,
  input  item_t item_i,
  output logic  cmd_valid_o,
  output cmd_t  cmd_o,
  input  logic  cmd_take_i
);

  cmd_t       mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push_ok;
  logic       take_ok;
  cmd_t       dec;

  // classify and clean up the codes
  always_comb begin
    dec            = '0;
    dec.is_start   = (item_i.operation == OP_START);
    dec.src        = AddrW'(item_i.src_addr);
    dec.dst        = AddrW'(item_i.dst_addr);
    dec.count      = item_i.byte_count;
    dec.data       = item_i.read_data;
    dec.mode.direction  = item_i.direction;
    dec.mode.advance    = (item_i.advance_mode == ADV_BAD) ? ADV_BOTH : item_i.advance_mode;
    dec.mode.io_side    = item_i.io_side;
    dec.mode.space      = (item_i.space == SPACE_BAD) ? SPACE_MEM : item_i.space;
    dec.mode.repeat_req = item_i.repeat_req;
  end

  assign full_o      = (cnt_q == 2'd2);
  assign push_ok     = push_i && !full_o;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign take_ok     = cmd_take_i && cmd_valid_o;
  assign cmd_o       = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_ok ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = take_ok ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q;
    case ({push_ok, take_ok})
      2'b10:   cnt_d = cnt_q + 2'd1;
      2'b01:   cnt_d = cnt_q - 2'd1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      mem_q[wr_ptr_q] <= dec;
    end
  end

endmodule

### src/bme_back.sv
// ----------------------------------------------------------------------------
// Block move engine back end
// Holds pointers, count and mode, executes one command per cycle while the result queue has room, queues results.
// ----------------------------------------------------------------------------
`include "block_move_engine_top_macros.svh"

module bme_back import bme_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    cmd_valid_i,
  input  cmd_t    cmd_i,
  output logic    cmd_take_o,
  output logic    empty_o,
  input  logic    pop_i,
  output result_t result_o
);

  localparam logic [AddrW-1:0] PtrOne = AddrW'(1);

  logic [AddrW-1:0] src_q, src_d;
  logic [AddrW-1:0] dst_q, dst_d;
  logic [15:0]      count_q, count_d;
  logic             busy_q, busy_d;
  mode_t            mode_q, mode_d;

  result_t          omem_q [2];
  logic             owr_q, ord_q;
  logic [1:0]       ocnt_q, ocnt_d;
  logic             take;
  logic             pop_ok;
  logic             take_data;
  result_t          res;
  logic [3:0]       extra;
  logic             vflag;

  assign take      = cmd_valid_i && (ocnt_q != 2'd2);
  assign cmd_take_o = take;
  assign take_data = take && !cmd_i.is_start;
  assign empty_o   = (ocnt_q == 2'd0);
  assign pop_ok    = pop_i && !empty_o;
  assign result_o  = omem_q[ord_q];

  always_comb begin
    case (mode_q.space)
      SPACE_IIO: extra = 4'd1;
      SPACE_XIO: extra = 4'd2;
      default:   extra = 4'd0;
    endcase
  end

  always_comb begin
    src_d   = src_q;
    dst_d   = dst_q;
    count_d = count_q;
    busy_d  = busy_q;
    mode_d  = mode_q;
    vflag   = 1'b0;
    res     = '0;
    if (cmd_i.is_start) begin
      src_d      = cmd_i.src;
      dst_d      = cmd_i.dst;
      count_d    = cmd_i.count;
      mode_d     = cmd_i.mode;
      busy_d     = 1'b1;
      res.cycles = cmd_i.mode.repeat_req ? CYC_REP_START : CYC_NONE;
    end else if (busy_q) begin
      res.write_valid = 1'b1;
      res.write_addr  = 16'(dst_q);
      res.write_data  = cmd_i.data;
      res.write_space = mode_q.io_side ? SPACE_MEM : mode_q.space;
      count_d         = count_q - 16'd1;
      if (mode_q.advance != ADV_DST) begin
        src_d = mode_q.direction ? src_q - PtrOne : src_q + PtrOne;
      end
      if (mode_q.advance != ADV_SRC) begin
        dst_d = mode_q.direction ? dst_q - PtrOne : dst_q + PtrOne;
      end
      if (mode_q.repeat_req) begin
        res.cycles = CYC_REP_BYTE + extra;
        if (count_d == 16'd0) begin
          busy_d = 1'b0;
        end
      end else begin
        res.cycles = CYC_SINGLE_BYTE + extra;
        busy_d     = 1'b0;
        vflag      = (count_d != 16'd0);
      end
    end
    res.read_addr  = busy_d ? 16'(src_d) : 16'd0;
    res.read_space = (busy_d && mode_d.io_side) ? mode_d.space : SPACE_MEM;
    res.done_res   = !busy_d;
    res.count_left = count_d;
    res.src_now    = 16'(src_d);
    res.dst_now    = 16'(dst_d);
    res.flag_v     = !busy_d && vflag;
  end

  always_comb begin
    case ({take, pop_ok})
      2'b10:   ocnt_d = ocnt_q + 2'd1;
      2'b01:   ocnt_d = ocnt_q - 2'd1;
      default: ocnt_d = ocnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_q   <= '0;
      dst_q   <= '0;
      count_q <= '0;
      busy_q  <= 1'b0;
      mode_q  <= '0;
      owr_q   <= 1'b0;
      ord_q   <= 1'b0;
      ocnt_q  <= 2'd0;
    end else begin
      if (take) begin
        src_q   <= src_d;
        dst_q   <= dst_d;
        count_q <= count_d;
        busy_q  <= busy_d;
        mode_q  <= mode_d;
        owr_q   <= !owr_q;
      end
      if (pop_ok) begin
        ord_q <= !ord_q;
      end
      ocnt_q <= ocnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      omem_q[owr_q] <= res;
    end
  end

  `BME_ASSERT_IMP(a_ocnt_bound, clk_i, rst_ni, 1'b1, ocnt_q != 2'd3)
  `BME_ASSERT_NXT(a_start_busy, clk_i, rst_ni, take && cmd_i.is_start, busy_q)
  `BME_ASSERT_IMP(a_fall_data, clk_i, rst_ni, $fell(busy_q), $past(take_data))
  `BME_ASSERT_NXT(a_single_ends, clk_i, rst_ni, take_data && busy_q && !mode_q.repeat_req,
                  !busy_q)

endmodule

### src/block_move_engine_top.sv
// ----------------------------------------------------------------------------
// Block move engine
// Byte block copy engine with separate command front end and execution back end.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: item_i with push/full. A start transaction loads source,
//   destination, count and mode; a data transaction carries the byte read at
//   the last requested address. Every accepted transaction yields one result.
//   Result channel: result_o with empty/pop. Each result holds the write to
//   perform (if any), the next read request, done, V and the tick count.
//   An accepted transaction is registered in the front-end queue, then executed
//   and its result registered in the result queue, from which it can be popped.
//   Throughput: one transaction per cycle while the result queue has room, set
//   by the pointer and count update in the back end.
//   Stall: two results queue at the output, then the back end holds, two
//   transactions queue in the front end, then full rises.
//   Reset: both queues empty, pointers, count and mode cleared, engine idle.
// ----------------------------------------------------------------------------
module block_move_engine_top import bme_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push,
  output logic    full,
  input  item_t   item_i,
  output logic    empty,
  input  logic    pop,
  output result_t result_o
);

  logic cmd_valid;
  cmd_t cmd;
  logic cmd_take;

  bme_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .item_i      (item_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_take_i  (cmd_take)
  );

  bme_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_take_o  (cmd_take),
    .empty_o     (empty),
    .pop_i       (pop),
    .result_o    (result_o)
  );

endmodule

### bench/block_move_engine_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Block move engine testbench
// Drives start and data transactions through the input queue and checks every
// result against a cycle-free model of the copy engine. It covers directed
// corner cases, random transfers, full drain pauses and a run without idling.
// ----------------------------------------------------------------------------
module block_move_engine_top_test;
  import bme_pkg::*;

  localparam logic DIR_INC    = 1'b0;
  localparam logic DIR_DEC    = 1'b1;
  localparam logic SIDE_WRSEL = 1'b0;
  localparam logic SIDE_RDSEL = 1'b1;
  localparam logic MOVE_ONE   = 1'b0;
  localparam logic MOVE_REP   = 1'b1;
  localparam int   STALL_LIMIT = 4000;
  localparam int   RANDOM_ITEMS = 450;
  localparam int   BURST_ITEMS  = 150;

  logic    clk_i;
  logic    rst_ni;
  logic    push;
  logic    full;
  item_t   item_i;
  logic    empty;
  logic    pop;
  result_t result_o;

  // engine model state
  logic [15:0] eng_src;
  logic [15:0] eng_dst;
  logic [15:0] eng_count;
  logic        eng_busy;
  mode_t       eng_mode;

  result_t pending_results[$];
  logic    tx_idle;
  logic    rx_idle;
  int      mismatches;
  int      results_seen;
  int      moves_sent;
  int      starts_sent;
  int      bytes_sent;
  int      stall_cycles;

  block_move_engine_top i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push    (push),
    .full    (full),
    .item_i  (item_i),
    .empty   (empty),
    .pop     (pop),
    .result_o(result_o)
  );

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  function automatic logic [15:0] next_ptr(logic [15:0] p);
    return (eng_mode.direction == DIR_DEC) ? p - 16'd1 : p + 16'd1;
  endfunction

  function automatic result_t engine_step(item_t it);
    result_t    r;
    logic       vflag;
    logic [3:0] extra;
    r = '0;
    vflag = 1'b0;
    if (it.operation == OP_START) begin
      eng_src = it.src_addr;
      eng_dst = it.dst_addr;
      eng_count = it.byte_count;
      eng_mode.direction = it.direction;
      eng_mode.advance = (it.advance_mode == ADV_BAD) ? ADV_BOTH : it.advance_mode;
      eng_mode.io_side = it.io_side;
      eng_mode.space = (it.space == SPACE_BAD) ? SPACE_MEM : it.space;
      eng_mode.repeat_req = it.repeat_req;
      eng_busy = 1'b1;
      r.cycles = (it.repeat_req == MOVE_REP) ? CYC_REP_START : CYC_NONE;
    end else if (eng_busy) begin
      extra = (eng_mode.space == SPACE_IIO) ? 4'd1 : (eng_mode.space == SPACE_XIO) ? 4'd2 : 4'd0;
      r.write_valid = 1'b1;
      r.write_addr = eng_dst;
      r.write_data = it.read_data;
      r.write_space = (eng_mode.io_side == SIDE_RDSEL) ? SPACE_MEM : eng_mode.space;
      eng_count = eng_count - 16'd1;
      if (eng_mode.advance != ADV_DST) eng_src = next_ptr(eng_src);
      if (eng_mode.advance != ADV_SRC) eng_dst = next_ptr(eng_dst);
      if (eng_mode.repeat_req == MOVE_REP) begin
        r.cycles = CYC_REP_BYTE + extra;
        if (eng_count == 16'd0) eng_busy = 1'b0;
      end else begin
        r.cycles = CYC_SINGLE_BYTE + extra;
        eng_busy = 1'b0;
        vflag = (eng_count != 16'd0);
      end
    end
    r.read_addr = eng_busy ? eng_src : 16'd0;
    r.read_space = (eng_busy && eng_mode.io_side == SIDE_RDSEL) ? eng_mode.space : SPACE_MEM;
    r.done_res = ~eng_busy;
    r.count_left = eng_count;
    r.src_now = eng_src;
    r.dst_now = eng_dst;
    r.flag_v = eng_busy ? 1'b0 : vflag;
    return r;
  endfunction

  function automatic item_t start_item(logic [15:0] src, logic [15:0] dst, logic [15:0] cnt,
                                       logic dir, logic [1:0] adv, logic side,
                                       logic [1:0] sp, logic rep);
    item_t it;
    it = {$urandom, $urandom};
    it.operation = OP_START;
    it.src_addr = src;
    it.dst_addr = dst;
    it.byte_count = cnt;
    it.direction = dir;
    it.advance_mode = adv;
    it.io_side = side;
    it.space = sp;
    it.repeat_req = rep;
    return it;
  endfunction

  function automatic item_t data_item(logic [7:0] value);
    item_t it;
    it = {$urandom, $urandom};
    it.operation = OP_DATA;
    it.read_data = value;
    return it;
  endfunction

  function automatic logic [15:0] rand_addr();
    if ($urandom_range(0, 4) == 0) return 16'hFFFE + 16'($urandom_range(0, 3));
    return 16'($urandom);
  endfunction

  task automatic send_item(input item_t it);
    while (tx_idle && $urandom_range(0, 99) < 12) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (full);
    if (it.operation == OP_START) starts_sent++;
    else if (eng_busy) bytes_sent++;
    pending_results.push_back(engine_step(it));
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic check_result(input result_t got);
    result_t want;
    string   bad;
    results_seen++;
    if (pending_results.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result %h", got);
      return;
    end
    want = pending_results.pop_front();
    bad = "";
    if (got.write_valid !== want.write_valid) bad = {bad, " write_valid"};
    if (got.write_addr !== want.write_addr) bad = {bad, " write_addr"};
    if (got.write_data !== want.write_data) bad = {bad, " write_data"};
    if (got.write_space !== want.write_space) bad = {bad, " write_space"};
    if (got.read_addr !== want.read_addr) bad = {bad, " read_addr"};
    if (got.read_space !== want.read_space) bad = {bad, " read_space"};
    if (got.done_res !== want.done_res) bad = {bad, " done_res"};
    if (got.count_left !== want.count_left) bad = {bad, " count_left"};
    if (got.src_now !== want.src_now) bad = {bad, " src_now"};
    if (got.dst_now !== want.dst_now) bad = {bad, " dst_now"};
    if (got.flag_v !== want.flag_v) bad = {bad, " flag_v"};
    if (got.cycles !== want.cycles) bad = {bad, " cycles"};
    if (bad != "") begin
      mismatches++;
      if (mismatches <= 10)
        $display("result %0d wrong in%s: expected %h, got %h", results_seen, bad, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pop && !empty) check_result(result_o);
      pop <= rx_idle ? ($urandom_range(0, 99) >= 12) : 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic test_directed();
    // data with the engine idle
    send_item(data_item(8'hA5));
    // single steps across the pointer wrap, V clear and set
    send_item(start_item(16'hFFFF, 16'h0000, 16'd1, DIR_INC, ADV_BOTH, SIDE_WRSEL, SPACE_MEM,
                         MOVE_ONE));
    send_item(data_item(8'h00));
    send_item(start_item(16'h0000, 16'hFFFF, 16'd0, DIR_DEC, ADV_SRC, SIDE_RDSEL, SPACE_IIO,
                         MOVE_ONE));
    send_item(data_item(8'hFF));
    send_item(start_item(16'h0000, 16'h0000, 16'd2, DIR_INC, ADV_DST, SIDE_WRSEL, SPACE_IIO,
                         MOVE_ONE));
    send_item(data_item(8'h5A));
    // repeat transfer to external io, destination only, counting down
    send_item(start_item(16'h8000, 16'h0001, 16'd2, DIR_DEC, ADV_DST, SIDE_WRSEL, SPACE_XIO,
                         MOVE_REP));
    send_item(data_item(8'hAA));
    send_item(data_item(8'h55));
    // invalid advance and space codes fall back to both pointers and memory
    send_item(start_item(16'h1234, 16'h4321, 16'd1, DIR_INC, ADV_BAD, SIDE_RDSEL, SPACE_BAD,
                         MOVE_REP));
    send_item(data_item(8'h81));
    // full 64K repeat, abandoned by a new start
    send_item(start_item(16'hFFFF, 16'hFFFE, 16'd0, DIR_INC, ADV_BOTH, SIDE_RDSEL, SPACE_XIO,
                         MOVE_REP));
    send_item(data_item(8'h01));
    send_item(data_item(8'h80));
    send_item(data_item(8'h7F));
    send_item(start_item(16'hFFFF, 16'hFFFF, 16'hFFFF, DIR_DEC, ADV_SRC, SIDE_RDSEL, SPACE_MEM,
                         MOVE_ONE));
    send_item(data_item(8'hFE));
    send_item(data_item(8'h3C));
  endtask

  task automatic send_transfer();
    logic [15:0] cnt;
    logic        rep;
    int          nbytes;
    if ($urandom_range(0, 9) == 0) begin
      send_item({$urandom, $urandom});
      return;
    end
    case ($urandom_range(0, 19))
      0:       cnt = 16'd0;
      1:       cnt = 16'hFFFF;
      2, 3:    cnt = 16'($urandom);
      default: cnt = 16'($urandom_range(1, 6));
    endcase
    rep = 1'($urandom_range(0, 1));
    if (rep == MOVE_ONE) nbytes = ($urandom_range(0, 19) == 0) ? 0 : 1;
    else if (cnt != 16'd0 && cnt <= 16'd8) nbytes = int'(cnt);
    else nbytes = $urandom_range(1, 4);
    if (rep == MOVE_REP && nbytes > 1 && $urandom_range(0, 9) == 0)
      nbytes = $urandom_range(0, nbytes - 1);
    send_item(start_item(rand_addr(), rand_addr(), cnt, 1'($urandom), 2'($urandom_range(0, 3)),
                         1'($urandom), 2'($urandom_range(0, 3)), rep));
    moves_sent++;
    repeat (nbytes) begin
      send_item(data_item(8'($urandom)));
      moves_sent++;
    end
    if ($urandom_range(0, 99) < 8) send_item(data_item(8'($urandom)));
  endtask

  task automatic test_random_transfers(input int target);
    int stop_at;
    stop_at = moves_sent + target;
    while (moves_sent < stop_at) send_transfer();
  endtask

  task automatic test_drain_pause();
    repeat (4) begin
      send_transfer();
      wait_drained();
    end
  endtask

  task automatic test_no_idle(input int target);
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    test_random_transfers(target);
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  initial begin
    rst_ni <= 1'b0;
    push <= 1'b0;
    pop <= 1'b0;
    item_i <= '0;
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    mismatches = 0;
    results_seen = 0;
    moves_sent = 0;
    starts_sent = 0;
    bytes_sent = 0;
    stall_cycles = 0;
    eng_src = '0;
    eng_dst = '0;
    eng_count = '0;
    eng_busy = 1'b0;
    eng_mode = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random_transfers(RANDOM_ITEMS / 2);
    test_drain_pause();
    test_no_idle(BURST_ITEMS);
    test_random_transfers(RANDOM_ITEMS / 2);

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (pending_results.size() != 0) mismatches++;
    $display("Checked %0d results from %0d starts and %0d copied bytes,", results_seen,
             starts_sent, bytes_sent);
    $display("including idle data, abandoned moves, pointer wrap and bad mode codes.");
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+src
src/bme_pkg.sv
src/bme_front.sv
src/bme_back.sv
src/block_move_engine_top.sv
bench/block_move_engine_top_test.sv
